/* rtl/core/nvi_pkg.sv */
// Shared types, codes and IEEE double helpers for the Neville interpolator.
// No dependencies; imported by nvi_fpu, neville_polynomial_interpolator and the bench.
`default_nettype none

package nvi_pkg;

    // Operations of the shared floating-point unit
    typedef enum logic [1:0] {
        FP_ADD,
        FP_SUB,
        FP_MUL,
        FP_DIV
    } fp_op_t;

    // One request to the floating-point unit
    typedef struct packed {
        fp_op_t      op;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    // Item kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DUP     = 2'd2;
    localparam logic [1:0] STATUS_DROPPED = 2'd3;

    // Quiet NaN produced by an invalid operation
    localparam logic [63:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QNAN_BIT     = 64'h0008_0000_0000_0000;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        T_IDLE,
        T_ONE,
        T_D0,
        T_D1,
        T_INIT,
        T_HO,
        T_HP,
        T_W,
        T_DEN,
        T_Q,
        T_ML,
        T_MU,
        T_CORR
    } nvi_state_t;

    // States of the floating-point unit
    typedef enum logic [2:0] {
        F_IDLE,
        F_ALIGN,
        F_ADD,
        F_PRE,
        F_MUL,
        F_DIV,
        F_NORM
    } fpu_state_t;

    function automatic logic is_nan(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] v);
        return v[62:0] == 63'd0;
    endfunction

    // |a| > |b|, false when either is NaN
    function automatic logic mag_greater(input logic [63:0] a, input logic [63:0] b);
        return !(is_nan(a) || is_nan(b)) && (a[62:0] > b[62:0]);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nvi_fpu.sv */
// Multi-cycle IEEE double unit: add, subtract, multiply, divide, round to nearest even.
// Depends on nvi_pkg. Bit-serial multiply and divide, one-bit-per-cycle normalisation.
`default_nettype none

module nvi_fpu (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire nvi_pkg::fpu_req_t req,
    output logic                  done,
    output logic [63:0]           result
);
    import nvi_pkg::*;

    fpu_state_t         fstate_reg, fstate_next;
    logic               done_reg, done_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [63:0]        res_reg, res_next;
    fp_op_t             op_reg, op_next;
    logic               sa_reg, sa_next, sb_reg, sb_next, s_reg, s_next;
    logic signed [12:0] ea_reg, ea_next, eb_reg, eb_next, e_reg, e_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [57:0]        xm_reg, xm_next, ym_reg, ym_next, m_reg, m_next;
    logic [106:0]       acc_reg, acc_next;
    logic [53:0]        rem_reg, rem_next;
    logic [56:0]        quo_reg, quo_next;

    // operand decode
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sb_eff;
    logic        sp_hit;
    logic [63:0] sp_val;

    // working values
    logic               a_big, s_big;
    logic signed [12:0] e_big, e_dif;
    logic [52:0]        m_big, m_small;
    logic [57:0]        small_w, shifted;
    logic [57:0]        sum_w;
    logic [53:0]        mul_sum;
    logic               div_ge;
    logic [53:0]        div_r;
    logic               rnd_inc;
    logic [53:0]        mant;
    logic signed [12:0] e_rnd;

    assign a_nan  = is_nan(req.a);
    assign b_nan  = is_nan(req.b);
    assign a_inf  = is_inf(req.a);
    assign b_inf  = is_inf(req.b);
    assign a_zero = is_zero(req.a);
    assign b_zero = is_zero(req.b);
    assign sb_eff = req.b[63] ^ (req.op == FP_SUB);

    // special operands settle at once
    always_comb
    begin
        sp_hit = 1'b1;
        sp_val = QNAN_DEFAULT;
        if (a_nan) begin
            sp_val = req.a | QNAN_BIT;
        end else if (b_nan) begin
            sp_val = req.b | QNAN_BIT;
        end else begin
            case (req.op)
                FP_ADD, FP_SUB:
                begin
                    if (a_inf && b_inf && (req.a[63] != sb_eff)) begin
                        sp_val = QNAN_DEFAULT;
                    end else if (a_inf) begin
                        sp_val = req.a;
                    end else if (b_inf) begin
                        sp_val = {sb_eff, 11'h7FF, 52'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
                FP_MUL:
                begin
                    if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                        sp_val = QNAN_DEFAULT;
                    end else if (a_inf || b_inf) begin
                        sp_val = {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
                    end else if (a_zero || b_zero) begin
                        sp_val = {req.a[63] ^ req.b[63], 63'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
                default:
                begin
                    if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                        sp_val = QNAN_DEFAULT;
                    end else if (a_inf || b_zero) begin
                        sp_val = {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
                    end else if (a_zero || b_inf) begin
                        sp_val = {req.a[63] ^ req.b[63], 63'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
            endcase
        end
    end

    // next state and datapath
    always_comb
    begin
        fstate_next = fstate_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        op_next     = op_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        s_next      = s_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        e_next      = e_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        xm_next     = xm_reg;
        ym_next     = ym_reg;
        m_next      = m_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;

        a_big   = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        e_big   = a_big ? ea_reg : eb_reg;
        s_big   = a_big ? sa_reg : sb_reg;
        m_big   = a_big ? ma_reg : mb_reg;
        m_small = a_big ? mb_reg : ma_reg;
        e_dif   = a_big ? (ea_reg - eb_reg) : (eb_reg - ea_reg);
        small_w = {2'b00, m_small, 3'b000};
        shifted = small_w >> e_dif[5:0];
        sum_w   = (sa_reg == sb_reg) ? (xm_reg + ym_reg) : (xm_reg - ym_reg);
        mul_sum = acc_reg[106:53] + {1'b0, (mb_reg[0] ? ma_reg : 53'd0)};
        div_ge  = rem_reg >= {1'b0, mb_reg};
        div_r   = div_ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
        rnd_inc = m_reg[2] && ((|m_reg[1:0]) || m_reg[3]);
        mant    = {1'b0, m_reg[55:3]} + {53'd0, rnd_inc};
        e_rnd   = mant[53] ? (e_reg + 13'sd1) : e_reg;

        case (fstate_reg)
            F_IDLE:
            begin
                if (start) begin
                    op_next = req.op;
                    sa_next = req.a[63];
                    sb_next = sb_eff;
                    ea_next = (req.a[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, req.a[62:52]});
                    eb_next = (req.b[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, req.b[62:52]});
                    ma_next = {req.a[62:52] != 11'd0, req.a[51:0]};
                    mb_next = {req.b[62:52] != 11'd0, req.b[51:0]};
                    if (sp_hit) begin
                        res_next  = sp_val;
                        done_next = 1'b1;
                    end else if ((req.op == FP_ADD) || (req.op == FP_SUB)) begin
                        fstate_next = F_ALIGN;
                    end else begin
                        sb_next     = req.b[63];
                        fstate_next = F_PRE;
                    end
                end
            end
            F_ALIGN:
            begin
                // line up the smaller operand, fold lost bits into sticky
                xm_next = {2'b00, m_big, 3'b000};
                if (e_dif >= 13'sd58) begin
                    ym_next = {57'd0, |m_small};
                end else begin
                    ym_next = shifted | {57'd0, ((shifted << e_dif[5:0]) != small_w)};
                end
                e_next      = e_big;
                s_next      = s_big;
                fstate_next = F_ADD;
            end
            F_ADD:
            begin
                m_next = sum_w;
                if (sum_w == 58'd0) begin
                    s_next = sa_reg & sb_reg;
                end
                fstate_next = F_NORM;
            end
            F_PRE:
            begin
                // bring subnormal significands up to a leading one
                if (ma_reg[52] && mb_reg[52]) begin
                    s_next   = sa_reg ^ sb_reg;
                    cnt_next = 6'd0;
                    acc_next = 107'd0;
                    rem_next = {1'b0, ma_reg};
                    quo_next = 57'd0;
                    fstate_next = (op_reg == FP_MUL) ? F_MUL : F_DIV;
                end else begin
                    if (!ma_reg[52]) begin
                        ma_next = {ma_reg[51:0], 1'b0};
                        ea_next = ea_reg - 13'sd1;
                    end
                    if (!mb_reg[52]) begin
                        mb_next = {mb_reg[51:0], 1'b0};
                        eb_next = eb_reg - 13'sd1;
                    end
                end
            end
            F_MUL:
            begin
                if (cnt_reg == 6'd53) begin
                    m_next      = {1'b0, acc_reg[105:50], |acc_reg[49:0]};
                    e_next      = ea_reg + eb_reg - 13'sd1023;
                    fstate_next = F_NORM;
                end else begin
                    acc_next = {1'b0, mul_sum, acc_reg[52:1]};
                    mb_next  = {1'b0, mb_reg[52:1]};
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == 6'd57) begin
                    m_next      = {1'b0, quo_reg[56:1], quo_reg[0] | (rem_reg != 54'd0)};
                    e_next      = ea_reg - eb_reg + 13'sd1022;
                    fstate_next = F_NORM;
                end else begin
                    quo_next = {quo_reg[55:0], div_ge};
                    rem_next = {div_r[52:0], 1'b0};
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            F_NORM:
            begin
                if (m_reg != 58'd0 && e_reg < -13'sd60) begin
                    // far below the smallest subnormal: sticky only
                    m_next = {57'd0, 1'b1};
                    e_next = 13'sd1;
                end else if (m_reg != 58'd0 &&
                             ((m_reg[57:56] != 2'b00) || (e_reg < 13'sd1))) begin
                    m_next = {1'b0, m_reg[57:2], m_reg[1] | m_reg[0]};
                    e_next = e_reg + 13'sd1;
                end else if (m_reg != 58'd0 && !m_reg[55] && (e_reg > 13'sd1)) begin
                    m_next = {m_reg[56:0], 1'b0};
                    e_next = e_reg - 13'sd1;
                end else begin
                    // round and pack
                    if (e_rnd >= 13'sd2047) begin
                        res_next = {s_reg, 11'h7FF, 52'd0};
                    end else if (mant[53]) begin
                        res_next = {s_reg, e_rnd[10:0], 52'd0};
                    end else begin
                        res_next = {s_reg, (mant[52] ? e_rnd[10:0] : 11'd0), mant[51:0]};
                    end
                    done_next   = 1'b1;
                    fstate_next = F_IDLE;
                end
            end
            default:
            begin
                fstate_next = F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fstate_reg <= F_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= 6'd0;
        end else begin
            fstate_reg <= fstate_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        op_reg  <= op_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        s_reg   <= s_next;
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        e_reg   <= e_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        xm_reg  <= xm_next;
        ym_reg  <= ym_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> fstate_reg == F_IDLE)
        else $error("fpu started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> fstate_reg == F_IDLE)
        else $error("fpu result strobed outside idle");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        fstate_reg == F_MUL |-> cnt_reg <= 6'd53)
        else $error("multiply step count overrun");

endmodule

`default_nettype wire

/* rtl/core/neville_polynomial_interpolator.sv */
// Top level of the Neville interpolator: sample store, tableau memories, sequencer.
// Depends on nvi_pkg and nvi_fpu.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+------------------------------
//  input   | kind, abscissa, ordinate           | start, taken when busy is low
//  result  | value, error_estimate, status      | done, one-cycle strobe
//
// Append and clear words finish at the accepting edge and give no result.
// A query with n >= 2 points runs a set-up (distances to the first and last points,
// seeding of the tableau), then n*(n-1)/2 tableau updates (four subtractions, a divide
// and two multiplies each) and one addition per column, all on the one shared
// floating-point unit; normalising shifts (cancellation, subnormals) lengthen an operation.
// Empty, dropped and single-point queries answer without the floating-point unit.
// After reset the store is empty; no clearing pass. The result side cannot stall.
`default_nettype none

module neville_polynomial_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [63:0] abscissa,
    input  wire logic [63:0] ordinate,
    output logic             done,
    output logic [63:0]      value,
    output logic [63:0]      error_estimate,
    output logic [1:0]       status
);
    import nvi_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // storage
    logic [63:0] abs_mem [MAX_POINTS];
    logic [63:0] ord_mem [MAX_POINTS];
    logic [63:0] c_mem   [MAX_POINTS];
    logic [63:0] d_mem   [MAX_POINTS];

    logic [63:0] abs_rdata_reg, ord_rdata_reg, c_rdata_reg, d_rdata_reg;

    nvi_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          issued_reg, issued_next;
    logic          rev_reg, rev_next;
    logic [IW-1:0] i_reg, i_next, m_reg, m_next;
    logic [63:0]   x_reg, x_next, d0_reg, d0_next, ho_reg, ho_next, hp_reg, hp_next;
    logic [63:0]   w_reg, w_next, q_reg, q_next, y_reg, y_next, corr_reg, corr_next;
    logic          done_reg, done_next;
    logic [63:0]   value_reg, value_next, err_reg, err_next;
    logic [1:0]    status_reg, status_next;

    // memory port controls
    logic          pt_we, c_we, d_we;
    logic [IW-1:0] pt_wa, cd_wa;
    logic [63:0]   c_wd, d_wd;
    logic          abs_re, ord_re, c_re, d_re;
    logic [IW-1:0] abs_ra, ord_ra, c_ra, d_ra;

    // floating-point unit
    logic        fpu_start, fpu_done;
    fpu_req_t    fpu_req;
    logic [63:0] fpu_res;

    logic [IW-1:0] nm1, last_i;

    assign nm1    = IW'(count_reg - CW'(1));
    assign last_i = IW'(count_reg - CW'(1) - CW'(m_reg));

    // working index to stored index
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] k, input logic r,
                                           input logic [IW-1:0] top);
        return r ? (top - k) : k;
    endfunction

    nvi_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fpu_start),
        .req    (fpu_req),
        .done   (fpu_done),
        .result (fpu_res)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        rev_next    = rev_reg;
        i_next      = i_reg;
        m_next      = m_reg;
        x_next      = x_reg;
        d0_next     = d0_reg;
        ho_next     = ho_reg;
        hp_next     = hp_reg;
        w_next      = w_reg;
        q_next      = q_reg;
        y_next      = y_reg;
        corr_next   = corr_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        err_next    = err_reg;
        status_next = status_reg;
        pt_we  = 1'b0;
        pt_wa  = count_reg[IW-1:0];
        c_we   = 1'b0;
        d_we   = 1'b0;
        cd_wa  = i_reg;
        c_wd   = ord_rdata_reg;
        d_wd   = ord_rdata_reg;
        abs_re = 1'b0;
        abs_ra = '0;
        ord_re = 1'b0;
        ord_ra = '0;
        c_re   = 1'b0;
        c_ra   = IW'(i_reg + IW'(1));
        d_re   = 1'b0;
        d_ra   = i_reg;
        fpu_start = 1'b0;
        fpu_req   = '{op: FP_SUB, a: x_reg, b: abs_rdata_reg};

        case (state_reg)
            T_IDLE:
            begin
                if (start) begin
                    case (kind)
                        KIND_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS)) begin
                                pt_we      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        KIND_QUERY:
                        begin
                            x_next = abscissa;
                            if (count_reg == '0) begin
                                done_next   = 1'b1;
                                value_next  = 64'd0;
                                err_next    = 64'd0;
                                status_next = STATUS_EMPTY;
                            end else if (ovf_reg) begin
                                done_next   = 1'b1;
                                value_next  = 64'd0;
                                err_next    = 64'd0;
                                status_next = STATUS_DROPPED;
                            end else if (count_reg == CW'(1)) begin
                                ord_re     = 1'b1;
                                state_next = T_ONE;
                            end else begin
                                abs_re     = 1'b1;
                                state_next = T_D0;
                            end
                        end
                        default:
                        begin
                            state_next = T_IDLE;
                        end
                    endcase
                end
            end
            T_ONE:
            begin
                done_next   = 1'b1;
                value_next  = ord_rdata_reg;
                err_next    = 64'd0;
                status_next = STATUS_OK;
                state_next  = T_IDLE;
            end
            T_D0:
            begin
                // distance to the first point; fetch the last one meanwhile
                fpu_req   = '{op: FP_SUB, a: x_reg, b: abs_rdata_reg};
                fpu_start = !issued_reg;
                if (!issued_reg) begin
                    abs_re = 1'b1;
                    abs_ra = nm1;
                end
                if (fpu_done) begin
                    d0_next    = fpu_res;
                    state_next = T_D1;
                end
            end
            T_D1:
            begin
                fpu_req   = '{op: FP_SUB, a: x_reg, b: abs_rdata_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    rev_next   = mag_greater(d0_reg, fpu_res);
                    i_next     = '0;
                    ord_re     = 1'b1;
                    ord_ra     = phys('0, mag_greater(d0_reg, fpu_res), nm1);
                    state_next = T_INIT;
                end
            end
            T_INIT:
            begin
                // seed both tableau columns with the ordinates
                c_we = 1'b1;
                d_we = 1'b1;
                if (i_reg == nm1) begin
                    y_next     = ord_rdata_reg;
                    i_next     = '0;
                    m_next     = IW'(1);
                    abs_re     = 1'b1;
                    abs_ra     = phys('0, rev_reg, nm1);
                    state_next = T_HO;
                end else begin
                    i_next = i_reg + IW'(1);
                    ord_re = 1'b1;
                    ord_ra = phys(IW'(i_reg + IW'(1)), rev_reg, nm1);
                end
            end
            T_HO:
            begin
                fpu_req   = '{op: FP_SUB, a: abs_rdata_reg, b: x_reg};
                fpu_start = !issued_reg;
                if (!issued_reg) begin
                    abs_re = 1'b1;
                    abs_ra = phys(IW'(i_reg + m_reg), rev_reg, nm1);
                end
                if (fpu_done) begin
                    ho_next    = fpu_res;
                    state_next = T_HP;
                end
            end
            T_HP:
            begin
                fpu_req   = '{op: FP_SUB, a: abs_rdata_reg, b: x_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    hp_next    = fpu_res;
                    c_re       = 1'b1;
                    d_re       = 1'b1;
                    state_next = T_W;
                end
            end
            T_W:
            begin
                fpu_req   = '{op: FP_SUB, a: c_rdata_reg, b: d_rdata_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    w_next     = fpu_res;
                    state_next = T_DEN;
                end
            end
            T_DEN:
            begin
                fpu_req   = '{op: FP_SUB, a: ho_reg, b: hp_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    if (is_zero(fpu_res)) begin
                        // equal abscissae
                        done_next   = 1'b1;
                        value_next  = 64'd0;
                        err_next    = 64'd0;
                        status_next = STATUS_DUP;
                        state_next  = T_IDLE;
                    end else begin
                        q_next     = fpu_res;
                        state_next = T_Q;
                    end
                end
            end
            T_Q:
            begin
                fpu_req   = '{op: FP_DIV, a: w_reg, b: q_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    q_next     = fpu_res;
                    state_next = T_ML;
                end
            end
            T_ML:
            begin
                fpu_req   = '{op: FP_MUL, a: hp_reg, b: q_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    d_we       = 1'b1;
                    d_wd       = fpu_res;
                    state_next = T_MU;
                end
            end
            T_MU:
            begin
                fpu_req   = '{op: FP_MUL, a: ho_reg, b: q_reg};
                fpu_start = !issued_reg;
                if (fpu_done) begin
                    c_we = 1'b1;
                    c_wd = fpu_res;
                    if (i_reg == last_i) begin
                        d_re       = 1'b1;
                        state_next = T_CORR;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        abs_re     = 1'b1;
                        abs_ra     = phys(IW'(i_reg + IW'(1)), rev_reg, nm1);
                        state_next = T_HO;
                    end
                end
            end
            T_CORR:
            begin
                // add the column's last correction
                fpu_req   = '{op: FP_ADD, a: y_reg, b: d_rdata_reg};
                fpu_start = !issued_reg;
                if (!issued_reg) begin
                    corr_next = d_rdata_reg;
                end
                if (fpu_done) begin
                    y_next = fpu_res;
                    if (m_reg == nm1) begin
                        done_next   = 1'b1;
                        value_next  = fpu_res;
                        err_next    = corr_reg;
                        status_next = STATUS_OK;
                        state_next  = T_IDLE;
                    end else begin
                        m_next     = m_reg + IW'(1);
                        i_next     = '0;
                        abs_re     = 1'b1;
                        abs_ra     = phys('0, rev_reg, nm1);
                        state_next = T_HO;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        issued_next = issued_reg;
        if (fpu_start) begin
            issued_next = 1'b1;
        end else if (fpu_done) begin
            issued_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= T_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            issued_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rev_reg    <= rev_next;
        i_reg      <= i_next;
        m_reg      <= m_next;
        x_reg      <= x_next;
        d0_reg     <= d0_next;
        ho_reg     <= ho_next;
        hp_reg     <= hp_next;
        w_reg      <= w_next;
        q_reg      <= q_next;
        y_reg      <= y_next;
        corr_reg   <= corr_next;
        value_reg  <= value_next;
        err_reg    <= err_next;
        status_reg <= status_next;
    end

    // sample store, one write and one read port each
    always_ff @(posedge clk)
    begin
        if (pt_we) begin
            abs_mem[pt_wa] <= abscissa;
            ord_mem[pt_wa] <= ordinate;
        end
        if (abs_re) begin
            abs_rdata_reg <= abs_mem[abs_ra];
        end
        if (ord_re) begin
            ord_rdata_reg <= ord_mem[ord_ra];
        end
    end

    // tableau columns
    always_ff @(posedge clk)
    begin
        if (c_we) begin
            c_mem[cd_wa] <= c_wd;
        end
        if (d_we) begin
            d_mem[cd_wa] <= d_wd;
        end
        if (c_re) begin
            c_rdata_reg <= c_mem[c_ra];
        end
        if (d_re) begin
            d_rdata_reg <= d_mem[d_ra];
        end
    end

    assign busy           = (state_reg != T_IDLE);
    assign done           = done_reg;
    assign value          = value_reg;
    assign error_estimate = err_reg;
    assign status         = status_reg;

    a_query_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query finished without a result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (value == 64'd0 && error_estimate == 64'd0))
        else $error("error result carries data");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

endmodule

`default_nettype wire

/* bench/tb_neville_polynomial_interpolator.sv */
// Self-checking bench for neville_polynomial_interpolator: a directed table, an overflow run, then random
// clear/append/query sequences checked against a real-valued tableau predictor.
// Depends on nvi_pkg and the RTL of the interpolator.
`default_nettype none

module tb_neville_polynomial_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import nvi_pkg::*;

    localparam int  STORE_DEPTH = 16;
    localparam int  RANDOM_WORDS = 1420;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [63:0] abscissa;
    logic [63:0] ordinate;
    logic        done;
    logic [63:0] value;
    logic [63:0] error_estimate;
    logic [1:0]  status;

    neville_polynomial_interpolator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .abscissa       (abscissa),
        .ordinate       (ordinate),
        .done           (done),
        .value          (value),
        .error_estimate (error_estimate),
        .status         (status)
    );

    typedef struct {
        logic [63:0] value;
        logic [63:0] estimate;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] x;
        logic [63:0] y;
        bit          typed;
        answer_t     ans;
    } row_t;

    // Predictor copy of the sample store
    real         sample_x [STORE_DEPTH];
    real         sample_y [STORE_DEPTH];
    int          sample_count;
    bit          dropped;
    answer_t     pending_answers[$];
    int          mismatches;
    int          answers_seen;
    int          queries_sent;
    int          dup_answers;
    int          drop_answers;
    longint      cycles = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers pending", cycles,
                     pending_answers.size());
            $display("tb_neville_polynomial_interpolator: FAIL");
            $finish;
        end
    end

    function automatic bit nan_bits(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    function automatic real abs_real(input real r);
        return $bitstoreal($realtobits(r) & 64'h7FFF_FFFF_FFFF_FFFF);
    endfunction

    // Evaluate the Neville tableau over the predictor store
    function automatic answer_t interpolate(input logic [63:0] xbits);
        answer_t res;
        real     xq, y, corr, xa, xb, ho, hp, w, den;
        real     up [STORE_DEPTH];
        real     lo [STORE_DEPTH];
        int      n, pos;
        bit      rev;
        res.value    = '0;
        res.estimate = '0;
        res.status   = STATUS_OK;
        n  = sample_count;
        xq = $bitstoreal(xbits);
        corr = 0.0;
        if (n == 0)
        begin
            res.status = STATUS_EMPTY;
            return res;
        end
        if (dropped)
        begin
            res.status = STATUS_DROPPED;
            return res;
        end
        if (n == 1)
        begin
            res.value = $realtobits(sample_y[0]);
            return res;
        end
        rev = abs_real(xq - sample_x[0]) > abs_real(xq - sample_x[n-1]);
        for (int i = 0; i < n; i++)
        begin
            up[i] = rev ? sample_y[n-1-i] : sample_y[i];
            lo[i] = up[i];
        end
        y   = up[n-1];
        pos = n - 1;
        for (int m = 1; m < n; m++)
        begin
            for (int i = 0; i < n - m; i++)
            begin
                xa  = rev ? sample_x[n-1-i] : sample_x[i];
                xb  = rev ? sample_x[n-1-i-m] : sample_x[i+m];
                ho  = xa - xq;
                hp  = xb - xq;
                w   = up[i+1] - lo[i];
                den = ho - hp;
                if (den == 0.0)
                begin
                    res.status = STATUS_DUP;
                    return res;
                end
                den   = w / den;
                lo[i] = hp * den;
                up[i] = ho * den;
            end
            pos--;
            corr = lo[pos];
            y    = y + corr;
        end
        res.value    = $realtobits(y);
        res.estimate = $realtobits(corr);
        return res;
    endfunction

    // Update the predictor for one accepted word; queue the answer of a query
    task automatic account_word(input logic [1:0] k, input logic [63:0] x,
                                input logic [63:0] y, input bit typed, input answer_t ans);
        answer_t res;
        case (k)
            KIND_APPEND:
            begin
                if (sample_count < STORE_DEPTH)
                begin
                    sample_x[sample_count] = $bitstoreal(x);
                    sample_y[sample_count] = $bitstoreal(y);
                    sample_count++;
                end
                else
                    dropped = 1'b1;
            end
            KIND_CLEAR:
            begin
                sample_count = 0;
                dropped      = 1'b0;
            end
            KIND_QUERY:
            begin
                res = typed ? ans : interpolate(x);
                pending_answers = {pending_answers, res};
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // Present one word after a random gap and hold it until it is taken
    task automatic send_word(input logic [1:0] k, input logic [63:0] x, input logic [63:0] y,
                             input bit typed, input answer_t ans);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 9) < 3)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        abscissa <= x;
        ordinate <= y;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        account_word(k, x, y, typed, ans);
    endtask

    // Check each answer against the oldest pending one
    always @(negedge clk)
    begin
        answer_t exp_ans;
        bit      ok;
        if (rst_n && done)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer: value %h est %h status %0d",
                             value, error_estimate, status);
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (exp_ans.status == STATUS_DUP)
                    dup_answers++;
                if (exp_ans.status == STATUS_DROPPED)
                    drop_answers++;
                // any NaN matches a NaN: payloads of propagated NaNs vary
                ok = (status === exp_ans.status)
                  && ((value === exp_ans.value)
                      || (nan_bits(value) && nan_bits(exp_ans.value)))
                  && ((error_estimate === exp_ans.estimate)
                      || (nan_bits(error_estimate) && nan_bits(exp_ans.estimate)));
                if (!ok)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %0d, got %h %h %0d",
                                 exp_ans.value, exp_ans.estimate, exp_ans.status,
                                 value, error_estimate, status);
                end
            end
        end
    end

    function automatic logic [63:0] random_coord();
        if ($urandom_range(0, 19) == 0)
            return {$urandom(), $urandom()};
        return $realtobits(real'(int'($urandom_range(0, 4000)) - 2000) / 16.0);
    endfunction

    initial
    begin
        row_t        table_rows[$];
        row_t        r;
        answer_t     none;
        answer_t     zeros_empty;
        answer_t     zeros_dup;
        answer_t     zeros_drop;
        answer_t     single;
        logic [63:0] used_x[$];
        logic [63:0] xv;
        int          words, npts, nq;

        start = 1'b0; kind = KIND_APPEND; abscissa = '0; ordinate = '0;
        rst_n = 1'b0;
        mismatches = 0; answers_seen = 0; queries_sent = 0;
        dup_answers = 0; drop_answers = 0; sample_count = 0; dropped = 1'b0;
        none        = '{64'd0, 64'd0, STATUS_OK};
        zeros_empty = '{64'd0, 64'd0, STATUS_EMPTY};
        zeros_dup   = '{64'd0, 64'd0, STATUS_DUP};
        zeros_drop  = '{64'd0, 64'd0, STATUS_DROPPED};
        single      = '{$realtobits(2.0), 64'd0, STATUS_OK};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed answers where they are plain, predictor elsewhere
        table_rows = '{
            '{KIND_QUERY,  $realtobits(1.0), '0, 1'b1, zeros_empty},
            '{KIND_UNUSED, '1, '1, 1'b0, none},
            '{KIND_APPEND, $realtobits(1.0), $realtobits(2.0), 1'b0, none},
            '{KIND_QUERY,  $realtobits(5.0), '0, 1'b1, single},
            '{KIND_APPEND, $realtobits(2.0), $realtobits(4.0), 1'b0, none},
            '{KIND_QUERY,  $realtobits(3.0), '0, 1'b0, none},
            '{KIND_QUERY,  $realtobits(0.0), '0, 1'b0, none},
            '{KIND_APPEND, $realtobits(4.0), $realtobits(-1.5), 1'b0, none},
            '{KIND_QUERY,  $realtobits(3.5), '0, 1'b0, none},
            '{KIND_QUERY,  '1, '0, 1'b0, none},
            '{KIND_QUERY,  64'h7FF0_0000_0000_0000, '0, 1'b0, none},
            '{KIND_APPEND, $realtobits(2.0), $realtobits(9.0), 1'b0, none},
            '{KIND_QUERY,  $realtobits(1.5), '0, 1'b1, zeros_dup},
            '{KIND_CLEAR,  '0, '0, 1'b0, none},
            '{KIND_QUERY,  '0, '0, 1'b1, zeros_empty},
            '{KIND_APPEND, '1, '1, 1'b0, none},
            '{KIND_APPEND, '0, '0, 1'b0, none},
            '{KIND_QUERY,  $realtobits(-2.0), '0, 1'b0, none},
            '{KIND_CLEAR,  '1, '1, 1'b0, none}
        };
        foreach (table_rows[i])
        begin
            r = table_rows[i];
            send_word(r.kind, r.x, r.y, r.typed, r.ans);
        end

        // Overflow the store, then query and recover
        for (int i = 0; i <= STORE_DEPTH; i++)
            send_word(KIND_APPEND, $realtobits(real'(i)), $realtobits(real'(i * i)), 1'b0, none);
        send_word(KIND_QUERY, $realtobits(3.0), '0, 1'b1, zeros_drop);
        send_word(KIND_CLEAR, '0, '0, 1'b0, none);

        // Random sequences: mostly small stores, a few full or overflowing ones
        words = 0;
        while (words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                send_word(KIND_CLEAR, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                          1'b0, none);
                words++;
            end
            case ($urandom_range(0, 19))
                0:       npts = $urandom_range(9, STORE_DEPTH + 2);
                1, 2, 3, 4, 5: npts = $urandom_range(5, 8);
                default: npts = $urandom_range(1, 4);
            endcase
            used_x.delete();
            for (int i = 0; i < npts; i++)
            begin
                if (used_x.size() > 0 && $urandom_range(0, 14) == 0)
                    xv = used_x[$urandom_range(0, used_x.size() - 1)];
                else
                    xv = random_coord();
                used_x = {used_x, xv};
                send_word(KIND_APPEND, xv, random_coord(), 1'b0, none);
                words++;
            end
            nq = $urandom_range(1, 3);
            for (int i = 0; i < nq; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    xv = used_x[$urandom_range(0, used_x.size() - 1)];
                else
                    xv = random_coord();
                send_word(KIND_QUERY, xv, {$urandom(), $urandom()}, 1'b0, none);
                words++;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                send_word(KIND_UNUSED, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                          1'b0, none);
                words++;
            end
        end

        start <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (50) @(posedge clk);

        $display("covered %0d queries (%0d duplicate-abscissa, %0d overflowed store),",
                 queries_sent, dup_answers, drop_answers);
        $display("%0d answers checked, %0d mismatches, %0d cycles",
                 answers_seen, mismatches, cycles);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("tb_neville_polynomial_interpolator: PASS");
        else
            $display("tb_neville_polynomial_interpolator: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
